FILE: rtl/attitude_state_feedback_core_defines.svh
// assertion macros for the attitude state feedback core
`ifndef ATTITUDE_STATE_FEEDBACK_CORE_DEFINES_SVH
`define ATTITUDE_STATE_FEEDBACK_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ASF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("attitude_state_feedback_core: check failed");

// next-cycle implication, disabled while in reset
`define ASF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("attitude_state_feedback_core: check failed");

`endif

FILE: rtl/asf_pkg.sv
`timescale 1ns / 1ps
package asf_pkg;

  // cordic defaults and arctangent table length
  localparam int CordicStepsDef = 16;
  localparam int AtanTabLen     = 24;

  // fixed-point constants
  localparam logic [11:0]        THRUST_RESET = 12'd3277;
  localparam logic signed [31:0] HALF_PI_Q24  = 32'sd26353589;
  localparam logic signed [25:0] PI_Q16       = 26'sd205887;
  localparam logic signed [25:0] TWO_PI_Q16   = 26'sd411775;
  localparam logic signed [59:0] ONE_Q28      = 60'sd268435456;
  localparam logic signed [59:0] ROUND_Q20    = 60'sd524288;

  // arctangent of 2^-i in q.24 radians
  function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sd13176795;
      5'd1:    v = 32'sd7778716;
      5'd2:    v = 32'sd4110060;
      5'd3:    v = 32'sd2086331;
      5'd4:    v = 32'sd1047214;
      5'd5:    v = 32'sd524117;
      5'd6:    v = 32'sd262123;
      5'd7:    v = 32'sd131069;
      5'd8:    v = 32'sd65536;
      5'd9:    v = 32'sd32768;
      5'd10:   v = 32'sd16384;
      5'd11:   v = 32'sd8192;
      5'd12:   v = 32'sd4096;
      5'd13:   v = 32'sd2048;
      5'd14:   v = 32'sd1024;
      5'd15:   v = 32'sd512;
      5'd16:   v = 32'sd256;
      5'd17:   v = 32'sd128;
      5'd18:   v = 32'sd64;
      5'd19:   v = 32'sd32;
      5'd20:   v = 32'sd16;
      5'd21:   v = 32'sd8;
      5'd22:   v = 32'sd4;
      5'd23:   v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // 3x6 feedback gains in q.16, columns roll pitch yaw rate_x rate_y rate_z
  function automatic logic signed [18:0] gain_lut(input logic [1:0] row,
                                                  input logic [2:0] col);
    logic signed [18:0] v;
    v = 19'sd0;
    case (row)
      2'd0: begin
        case (col)
          3'd0:    v = -19'sd54107;
          3'd1:    v = 19'sd28266;
          3'd2:    v = -19'sd4358;
          3'd3:    v = -19'sd8480;
          3'd4:    v = -19'sd1186;
          3'd5:    v = -19'sd24524;
          default: v = 19'sd0;
        endcase
      end
      2'd1: begin
        case (col)
          3'd0:    v = -19'sd17315;
          3'd1:    v = 19'sd92380;
          3'd2:    v = -19'sd4103;
          3'd3:    v = 19'sd944;
          3'd4:    v = 19'sd30907;
          3'd5:    v = -19'sd16377;
          default: v = 19'sd0;
        endcase
      end
      2'd2: begin
        case (col)
          3'd0:    v = -19'sd10702;
          3'd1:    v = -19'sd21319;
          3'd2:    v = 19'sd162090;
          3'd3:    v = 19'sd5027;
          3'd4:    v = 19'sd7825;
          3'd5:    v = 19'sd98815;
          default: v = 19'sd0;
        endcase
      end
      default: v = 19'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/attitude_state_feedback_core.sv
`timescale 1ns / 1ps
// attitude state feedback core
// input channel (in_valid_i / in_ready_o) takes one word: quaternion quat_w..quat_z
// in q1.14 and body rates rate_x..rate_z in q5.10. output channel
// (out_valid_o / out_ready_i) gives one word per input: torques in q3.12, the
// thrust setting and the unwrapped roll, pitch and yaw in q7.16.
// config channel (cfg_valid_i / cfg_ready_o) writes thrust_level_i, always ready;
// write it only while the core is idle.
// the sequencer steps one multiplier, one square-root step, one divide step
// and one cordic rotation per cycle between acceptance and result.
// in_ready_o is high only while the sequencer is idle; a finished word sits in
// the output register, so the next item may be taken while it waits.
// if the receiver stalls, a second result waits in the done state until the
// output register frees up.
// reset: thrust 0.8, stored quaternion identity, stored angles zero, no output.
`include "attitude_state_feedback_core_defines.svh"

module attitude_state_feedback_core
  import asf_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] torque_x_o,
  output logic signed [15:0] torque_y_o,
  output logic signed [15:0] torque_z_o,
  output logic [11:0]        thrust_out_o,
  output logic signed [23:0] roll_angle_o,
  output logic signed [23:0] pitch_angle_o,
  output logic signed [23:0] yaw_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [11:0]        thrust_level_i
);

  localparam int NSTEPS = (CORDIC_STEPS < AtanTabLen) ? CORDIC_STEPS : AtanTabLen;
  localparam logic [4:0]  K_CORD_LAST = 5'(NSTEPS - 1);
  localparam logic [4:0]  K_SQRT_LAST = 5'd28;
  localparam logic [4:0]  K_DIV_LAST  = 5'd15;
  localparam logic [57:0] SQ_START    = 58'(1) << 56;

  typedef enum logic [3:0] {
    S_IDLE, S_SQR, S_SQRT, S_DINIT, S_DIV, S_DOT, S_ROT, S_PSQ,
    S_CINIT, S_CORD, S_UNW, S_GAIN, S_DONE
  } state_e;

  state_e state_q;
  logic [4:0] k_q;
  logic [2:0] t_q;
  logic [1:0] cidx_q;

  logic signed [15:0] qin_q [4];
  logic signed [15:0] rate_q [3];
  logic signed [15:0] qn_q [4];
  logic signed [15:0] last_q [4];
  logic               seen_q;
  logic signed [23:0] last_ang_q [3];
  logic [11:0]        thrust_q;

  logic signed [29:0] mul_a, mul_b;
  logic signed [59:0] prod_q, acc_q, sum_w;

  logic [57:0] rad_q, root_q, bit_q, sq_try, root_nx, rad_nx;
  logic        sq_ge, sq_sel_q;
  logic [24:0] n_q;
  logic [28:0] c_q;

  logic [38:0] rem_q, rem_nx;
  logic [39:0] dsr_q;
  logic [15:0] quo_q, quo_nx, dq_mag;
  logic        div_ge;
  logic signed [15:0] qn_val;

  logic signed [31:0] rt_q [5];
  logic signed [32:0] neg_r20;
  logic signed [29:0] s_w;

  logic signed [35:0] cx_q, cy_q, cx_nx, cy_nx, x0, y0;
  logic signed [31:0] cz_q, cz_nx, z0, zr;
  logic signed [23:0] ang_raw_q;
  logic signed [25:0] d_w, uw;
  logic signed [23:0] uw_sat;

  logic signed [59:0] tsh;
  logic signed [15:0] tq_sat;
  logic signed [15:0] tq_q [3];

  logic               out_valid_q;
  logic signed [15:0] trq_o_q [3];
  logic [11:0]        thr_o_q;
  logic signed [23:0] ang_o_q [3];

  // doubled q1.14 operand
  function automatic logic signed [29:0] dbl(input logic signed [15:0] v);
    return 30'(v) <<< 1;
  endfunction

  // index of the last step of each accumulate phase, the one that adds the final product
  function automatic logic [4:0] mac_last(input state_e s);
    logic [4:0] v;
    case (s)
      S_SQR:   v = 5'd4;
      S_DOT:   v = 5'd4;
      S_ROT:   v = 5'd2;
      S_PSQ:   v = 5'd1;
      S_GAIN:  v = 5'd6;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  // accumulator start value for a rotation term
  function automatic logic signed [59:0] rot_init(input logic [2:0] t);
    return (t == 3'd0 || t == 3'd4) ? ONE_Q28 : 60'sd0;
  endfunction

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQR: begin
        mul_a = 30'(qin_q[k_q[1:0]]);
        mul_b = 30'(qin_q[k_q[1:0]]);
      end
      S_DOT: begin
        mul_a = 30'(qn_q[k_q[1:0]]);
        mul_b = 30'(last_q[k_q[1:0]]);
      end
      S_ROT: begin
        case ({t_q, k_q[0]})
          4'b0000: begin mul_a = -dbl(last_q[2]); mul_b = 30'(last_q[2]); end
          4'b0001: begin mul_a = -dbl(last_q[3]); mul_b = 30'(last_q[3]); end
          4'b0010: begin mul_a = dbl(last_q[1]);  mul_b = 30'(last_q[2]); end
          4'b0011: begin mul_a = dbl(last_q[0]);  mul_b = 30'(last_q[3]); end
          4'b0100: begin mul_a = dbl(last_q[1]);  mul_b = 30'(last_q[3]); end
          4'b0101: begin mul_a = -dbl(last_q[0]); mul_b = 30'(last_q[2]); end
          4'b0110: begin mul_a = dbl(last_q[2]);  mul_b = 30'(last_q[3]); end
          4'b0111: begin mul_a = dbl(last_q[0]);  mul_b = 30'(last_q[1]); end
          4'b1000: begin mul_a = -dbl(last_q[1]); mul_b = 30'(last_q[1]); end
          4'b1001: begin mul_a = -dbl(last_q[2]); mul_b = 30'(last_q[2]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_PSQ: begin
        mul_a = s_w;
        mul_b = s_w;
      end
      S_GAIN: begin
        mul_a = 30'(gain_lut(t_q[1:0], k_q[2:0]));
        case (k_q[2:0])
          3'd0:    mul_b = 30'(last_ang_q[0]);
          3'd1:    mul_b = 30'(last_ang_q[1]);
          3'd2:    mul_b = 30'(last_ang_q[2]);
          3'd3:    mul_b = 30'(rate_q[0]) <<< 6;
          3'd4:    mul_b = 30'(rate_q[1]) <<< 6;
          3'd5:    mul_b = 30'(rate_q[2]) <<< 6;
          default: mul_b = '0;
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum_w = acc_q + prod_q;

  // one square-root step
  always_comb begin
    sq_try  = root_q + bit_q;
    sq_ge   = rad_q >= sq_try;
    root_nx = sq_ge ? (root_q >> 1) + bit_q : root_q >> 1;
    rad_nx  = sq_ge ? rad_q - sq_try : rad_q;
  end

  // one restoring divide step and the signed quotient
  always_comb begin
    div_ge = {1'b0, rem_q} >= dsr_q;
    rem_nx = div_ge ? rem_q - dsr_q[38:0] : rem_q;
    quo_nx = {quo_q[14:0], div_ge};
    dq_mag = qin_q[t_q[1:0]][15] ? 16'(-qin_q[t_q[1:0]]) : 16'(qin_q[t_q[1:0]]);
    if (n_q == '0) begin
      qn_val = '0;
    end else if (qin_q[t_q[1:0]][15]) begin
      qn_val = -signed'(quo_nx);
    end else begin
      qn_val = signed'(quo_nx);
    end
  end

  // pitch sine, clamped to one
  always_comb begin
    neg_r20 = -33'(rt_q[2]);
    if (neg_r20 > 33'sd268435456) begin
      s_w = 30'sd268435456;
    end else if (neg_r20 < -33'sd268435456) begin
      s_w = -30'sd268435456;
    end else begin
      s_w = 30'(neg_r20);
    end
  end

  // cordic start vector with quadrant fold
  always_comb begin
    logic signed [35:0] xs, ys;
    case (cidx_q)
      2'd0:    begin ys = 36'(rt_q[3]); xs = 36'(rt_q[4]); end
      2'd1:    begin ys = 36'(s_w);     xs = signed'(36'(c_q)); end
      default: begin ys = 36'(rt_q[1]); xs = 36'(rt_q[0]); end
    endcase
    if (xs < 0) begin
      if (ys >= 0) begin
        x0 = ys;  y0 = -xs; z0 = HALF_PI_Q24;
      end else begin
        x0 = -ys; y0 = xs;  z0 = -HALF_PI_Q24;
      end
    end else begin
      x0 = xs; y0 = ys; z0 = '0;
    end
  end

  // one cordic vectoring rotation
  always_comb begin
    if (cy_q > 0) begin
      cx_nx = cx_q + (cy_q >>> k_q);
      cy_nx = cy_q - (cx_q >>> k_q);
      cz_nx = cz_q + atan_lut(k_q);
    end else begin
      cx_nx = cx_q - (cy_q >>> k_q);
      cy_nx = cy_q + (cx_q >>> k_q);
      cz_nx = cz_q - atan_lut(k_q);
    end
    zr = cz_nx + 32'sd128;
  end

  // unwrap against the stored angle and saturate
  always_comb begin
    d_w = 26'(ang_raw_q) - 26'(last_ang_q[cidx_q]);
    uw  = 26'(ang_raw_q);
    if (seen_q) begin
      if (d_w > PI_Q16) begin
        uw = 26'(ang_raw_q) - TWO_PI_Q16;
      end else if (d_w < -PI_Q16) begin
        uw = 26'(ang_raw_q) + TWO_PI_Q16;
      end
    end
    if (uw > 26'sd8388607) begin
      uw_sat = 24'sd8388607;
    end else if (uw < -26'sd8388608) begin
      uw_sat = -24'sd8388608;
    end else begin
      uw_sat = 24'(uw);
    end
  end

  // torque rounding and saturation
  always_comb begin
    tsh = sum_w >>> 20;
    if (tsh > 60'sd32767) begin
      tq_sat = 16'sd32767;
    end else if (tsh < -60'sd32768) begin
      tq_sat = -16'sd32768;
    end else begin
      tq_sat = 16'(tsh);
    end
  end

  // sequencer and all registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      t_q         <= '0;
      cidx_q      <= '0;
      qin_q       <= '{default: '0};
      rate_q      <= '{default: '0};
      qn_q        <= '{default: '0};
      last_q      <= '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      seen_q      <= 1'b0;
      last_ang_q  <= '{default: '0};
      thrust_q    <= THRUST_RESET;
      prod_q      <= '0;
      acc_q       <= '0;
      rad_q       <= '0;
      root_q      <= '0;
      bit_q       <= '0;
      sq_sel_q    <= 1'b0;
      n_q         <= '0;
      c_q         <= '0;
      rem_q       <= '0;
      dsr_q       <= '0;
      quo_q       <= '0;
      rt_q        <= '{default: '0};
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      ang_raw_q   <= '0;
      tq_q        <= '{default: '0};
      out_valid_q <= 1'b0;
      trq_o_q     <= '{default: '0};
      thr_o_q     <= '0;
      ang_o_q     <= '{default: '0};
    end else begin
      // configuration write
      if (cfg_valid_i) begin
        thrust_q <= thrust_level_i;
      end
      // output word taken, unless the done state refills it
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      prod_q <= mul_a * mul_b;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            qin_q  <= '{quat_w_i, quat_x_i, quat_y_i, quat_z_i};
            rate_q <= '{rate_x_i, rate_y_i, rate_z_i};
            k_q    <= '0;
            t_q    <= '0;
            acc_q  <= '0;
            state_q <= S_SQR;
          end
        end

        // multiply-accumulate phases, one product per cycle
        S_SQR, S_DOT, S_ROT, S_PSQ, S_GAIN: begin
          if (k_q == mac_last(state_q)) begin
            k_q <= '0;
            case (state_q)
              S_SQR: begin
                rad_q    <= {9'b0, sum_w[32:0], 16'b0};
                root_q   <= '0;
                bit_q    <= SQ_START;
                sq_sel_q <= 1'b0;
                state_q  <= S_SQRT;
              end
              S_DOT: begin
                for (int i = 0; i < 4; i++) begin
                  last_q[i] <= (seen_q && sum_w[59]) ? -qn_q[i] : qn_q[i];
                end
                t_q     <= '0;
                acc_q   <= rot_init(3'd0);
                state_q <= S_ROT;
              end
              S_ROT: begin
                rt_q[t_q] <= sum_w[31:0];
                if (t_q == 3'd4) begin
                  t_q     <= '0;
                  acc_q   <= '0;
                  state_q <= S_PSQ;
                end else begin
                  t_q   <= t_q + 3'd1;
                  acc_q <= rot_init(t_q + 3'd1);
                end
              end
              S_PSQ: begin
                rad_q    <= SQ_START - 58'(sum_w[56:0]);
                root_q   <= '0;
                bit_q    <= SQ_START;
                sq_sel_q <= 1'b1;
                state_q  <= S_SQRT;
              end
              S_GAIN: begin
                tq_q[t_q[1:0]] <= tq_sat;
                if (t_q == 3'd2) begin
                  seen_q  <= 1'b1;
                  state_q <= S_DONE;
                end else begin
                  t_q   <= t_q + 3'd1;
                  acc_q <= ROUND_Q20;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end else begin
            k_q <= k_q + 5'd1;
            if (k_q != '0) begin
              acc_q <= sum_w;
            end
          end
        end

        // square root, two radicand bits per cycle
        S_SQRT: begin
          rad_q  <= rad_nx;
          root_q <= root_nx;
          bit_q  <= bit_q >> 2;
          if (k_q == K_SQRT_LAST) begin
            k_q <= '0;
            if (!sq_sel_q) begin
              n_q     <= root_nx[24:0];
              t_q     <= '0;
              state_q <= S_DINIT;
            end else begin
              c_q     <= root_nx[28:0];
              cidx_q  <= '0;
              state_q <= S_CINIT;
            end
          end else begin
            k_q <= k_q + 5'd1;
          end
        end

        // normalise one component: rounded magnitude over the norm
        S_DINIT: begin
          rem_q   <= {1'b0, dq_mag, 22'b0} + 39'(n_q >> 1);
          dsr_q   <= {n_q, 15'b0};
          quo_q   <= '0;
          k_q     <= '0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          dsr_q <= dsr_q >> 1;
          if (k_q == K_DIV_LAST) begin
            k_q <= '0;
            qn_q[t_q[1:0]] <= qn_val;
            if (t_q == 3'd3) begin
              t_q     <= '0;
              acc_q   <= '0;
              state_q <= S_DOT;
            end else begin
              t_q     <= t_q + 3'd1;
              state_q <= S_DINIT;
            end
          end else begin
            k_q <= k_q + 5'd1;
          end
        end

        S_CINIT: begin
          cx_q    <= x0;
          cy_q    <= y0;
          cz_q    <= z0;
          k_q     <= '0;
          state_q <= S_CORD;
        end

        S_CORD: begin
          cx_q <= cx_nx;
          cy_q <= cy_nx;
          cz_q <= cz_nx;
          if (k_q == K_CORD_LAST) begin
            k_q       <= '0;
            ang_raw_q <= zr[31:8];
            state_q   <= S_UNW;
          end else begin
            k_q <= k_q + 5'd1;
          end
        end

        S_UNW: begin
          last_ang_q[cidx_q] <= uw_sat;
          if (cidx_q == 2'd2) begin
            t_q     <= '0;
            k_q     <= '0;
            acc_q   <= ROUND_Q20;
            state_q <= S_GAIN;
          end else begin
            cidx_q  <= cidx_q + 2'd1;
            state_q <= S_CINIT;
          end
        end

        // hand the word to the output register once it is free
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            trq_o_q     <= tq_q;
            thr_o_q     <= thrust_q;
            ang_o_q     <= last_ang_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign torque_x_o    = trq_o_q[0];
  assign torque_y_o    = trq_o_q[1];
  assign torque_z_o    = trq_o_q[2];
  assign thrust_out_o  = thr_o_q;
  assign roll_angle_o  = ang_o_q[0];
  assign pitch_angle_o = ang_o_q[1];
  assign yaw_angle_o   = ang_o_q[2];

  // checks
  `ASF_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_SQR && !in_ready_o)
  `ASF_ASSERT_IMPL(a_word_from_done, clk_i, rst_ni, out_valid_o && !$past(out_valid_o), $past(state_q == S_DONE))
  `ASF_ASSERT_NEXT(a_seen_sticks, clk_i, rst_ni, seen_q, seen_q)
  `ASF_ASSERT_IMPL(a_div_rem_bound, clk_i, rst_ni, state_q == S_DIV && n_q != '0, 41'(rem_q) < (41'(dsr_q) << 1))
  `ASF_ASSERT_IMPL(a_cordic_count, clk_i, rst_ni, state_q == S_CORD, k_q <= K_CORD_LAST)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import asf_pkg::*;

  typedef struct packed {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [15:0] rx, ry, rz;
  } att_item_t;

  typedef struct packed {
    logic signed [15:0] tx, ty, tz;
    logic [11:0]        thr;
    logic signed [23:0] roll, pitch, yaw;
  } att_word_t;

  typedef struct packed {
    att_item_t item;
    logic      typed;
    att_word_t word;
  } stim_row_t;

  localparam int     STEPS   = 16;
  localparam longint PI16    = 205887;
  localparam longint TWOPI16 = 411775;
  localparam longint HPI24   = 26353589;
  localparam longint UNIT28  = 268435456;
  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint K [3][6] = '{
    '{-54107,  28266,  -4358, -8480, -1186, -24524},
    '{-17315,  92380,  -4103,   944, 30907, -16377},
    '{-10702, -21319, 162090,  5027,  7825,  98815}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] torque_x_o, torque_y_o, torque_z_o;
  logic [11:0] thrust_out_o;
  logic signed [23:0] roll_angle_o, pitch_angle_o, yaw_angle_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [11:0] thrust_level_i = '0;

  // model state
  logic      seen_m;
  longint    last_q [4];
  longint    last_a [3];
  logic [11:0] thrust_m;

  att_word_t expected_words [$];
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  logic      long_hold_req = 1'b0;

  attitude_state_feedback_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .rate_x_i, .rate_y_i, .rate_z_i,
    .out_valid_o, .out_ready_i,
    .torque_x_o, .torque_y_o, .torque_z_o, .thrust_out_o,
    .roll_angle_o, .pitch_angle_o, .yaw_angle_o,
    .cfg_valid_i, .cfg_ready_o, .thrust_level_i
  );

  // clock
  always #2 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vectoring cordic, angle accumulated in q.24 and returned rounded to q.16
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, nx;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HPI24;
      end else begin
        t = x; x = -y; y = t; z = -HPI24;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_Q24[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_Q24[i];
      end
      x = nx;
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // attitude and torque for one accepted word, updating the model state
  function automatic att_word_t attitude_feedback(att_item_t it);
    longint q [4], qn [4], ang [3], rate [3];
    longint unsigned sum, n, mag;
    longint dot, r00, r10, r20, r21, r22, s, c, acc, v, d;
    att_word_t w;
    q = '{it.qw, it.qx, it.qy, it.qz};
    rate = '{it.rx, it.ry, it.rz};
    sum = 0;
    for (int i = 0; i < 4; i++) sum += q[i] * q[i];
    n = int_sqrt(sum << 16);
    for (int i = 0; i < 4; i++) begin
      if (n == 0) begin
        qn[i] = 0;
      end else begin
        mag = (q[i] < 0 ? -q[i] : q[i]) << 22;
        v = (mag + n / 2) / n;
        qn[i] = q[i] < 0 ? -v : v;
      end
    end
    // hemisphere continuity
    dot = 0;
    for (int i = 0; i < 4; i++) dot += qn[i] * last_q[i];
    if (seen_m && dot < 0)
      for (int i = 0; i < 4; i++) qn[i] = -qn[i];
    r00 = UNIT28 - 2 * (qn[2] * qn[2] + qn[3] * qn[3]);
    r10 = 2 * (qn[1] * qn[2] + qn[0] * qn[3]);
    r20 = 2 * (qn[1] * qn[3] - qn[0] * qn[2]);
    r21 = 2 * (qn[2] * qn[3] + qn[0] * qn[1]);
    r22 = UNIT28 - 2 * (qn[1] * qn[1] + qn[2] * qn[2]);
    s = clip(-r20, -UNIT28, UNIT28);
    c = longint'(int_sqrt((64'd1 << 56) - longint'(s * s)));
    ang[0] = vector_angle(r21, r22);
    ang[1] = vector_angle(s, c);
    ang[2] = vector_angle(r10, r00);
    // unwrap against the stored angles
    for (int i = 0; i < 3; i++) begin
      if (seen_m) begin
        d = ang[i] - last_a[i];
        if (d > PI16) ang[i] -= TWOPI16;
        if (d < -PI16) ang[i] += TWOPI16;
      end
      ang[i] = clip(ang[i], -8388608, 8388607);
      last_a[i] = ang[i];
    end
    for (int i = 0; i < 4; i++) last_q[i] = qn[i];
    seen_m = 1'b1;
    // gain matrix times state
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) acc += K[r][i] * ang[i];
      for (int i = 0; i < 3; i++) acc += K[r][3 + i] * rate[i] * 64;
      acc = clip((acc + (64'sd1 <<< 19)) >>> 20, -32768, 32767);
      if (r == 0) w.tx = acc[15:0];
      else if (r == 1) w.ty = acc[15:0];
      else w.tz = acc[15:0];
    end
    w.thr = thrust_m;
    w.roll = ang[0][23:0];
    w.pitch = ang[1][23:0];
    w.yaw = ang[2][23:0];
    return w;
  endfunction

  // offer one word; when gap is nonzero, drop the valid and idle before returning
  task automatic send_word(att_item_t it, logic typed, att_word_t tw, int gap);
    att_word_t pw;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i} = {it.qw, it.qx, it.qy, it.qz};
    {rate_x_i, rate_y_i, rate_z_i} = {it.rx, it.ry, it.rz};
    do @(posedge clk_i); while (!in_ready_o);
    pw = attitude_feedback(it);
    expected_words.push_back(typed ? tw : pw);
    n_sent++;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    do @(posedge clk_i); while (expected_words.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_thrust(logic [11:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    thrust_level_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    thrust_m = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode_left, mode, hold;
    logic held;
    mode_left = 0; mode = 0; hold = 0; held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !held) begin
        held = 1'b1;
        hold = 1500;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(200, 800);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        out_ready_i = 1'b0;
      end else begin
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = ($urandom_range(0, 3) != 0);
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    att_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        e = expected_words.pop_front();
        n_checked++;
        if (torque_x_o !== e.tx) begin
          $error("torque_x exp %0d got %0d", e.tx, torque_x_o); n_errors++;
        end
        if (torque_y_o !== e.ty) begin
          $error("torque_y exp %0d got %0d", e.ty, torque_y_o); n_errors++;
        end
        if (torque_z_o !== e.tz) begin
          $error("torque_z exp %0d got %0d", e.tz, torque_z_o); n_errors++;
        end
        if (thrust_out_o !== e.thr) begin
          $error("thrust_out exp %0d got %0d", e.thr, thrust_out_o); n_errors++;
        end
        if (roll_angle_o !== e.roll) begin
          $error("roll_angle exp %0d got %0d", e.roll, roll_angle_o); n_errors++;
        end
        if (pitch_angle_o !== e.pitch) begin
          $error("pitch_angle exp %0d got %0d", e.pitch, pitch_angle_o); n_errors++;
        end
        if (yaw_angle_o !== e.yaw) begin
          $error("yaw_angle exp %0d got %0d", e.yaw, yaw_angle_o); n_errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #10ms;
    $display("attitude_state_feedback_core: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t dir [];
    att_word_t zw;
    att_item_t it;
    logic [11:0] thr_set [4];
    int burst, gap, kind;
    longint walk [4];
    // level attitude: the cordic leaves one lsb on each angle, torques round to zero
    zw = '{tx: 0, ty: 0, tz: 0, thr: 12'd3277, roll: 1, pitch: 1, yaw: 1};
    dir = '{
      '{'{16384, 0, 0, 0, 0, 0, 0}, 1'b1, zw},
      '{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, zw},
      '{'{-16384, 0, 0, 0, 0, 0, 0}, 1'b1, zw},
      '{'{16384, 0, 0, 0, 32767, 32767, 32767}, 1'b0, zw},
      '{'{16384, 0, 0, 0, -32768, -32768, -32768}, 1'b0, zw},
      '{'{32767, 32767, 32767, 32767, 0, 0, 0}, 1'b0, zw},
      '{'{-32768, -32768, -32768, -32768, 1, -1, 1}, 1'b0, zw},
      '{'{0, 32767, 0, 0, 0, 0, 0}, 1'b0, zw},
      '{'{0, -32768, 1, 0, 0, 0, 0}, 1'b0, zw},
      '{'{0, 0, 0, 16384, 0, 0, 0}, 1'b0, zw},
      '{'{0, 0, 1, -16384, 0, 0, 0}, 1'b0, zw},
      '{'{11585, 0, 11585, 0, 0, 0, 0}, 1'b0, zw},
      '{'{11585, 0, -11585, 0, 0, 0, 0}, 1'b0, zw},
      '{'{16384, 100, 200, -300, 32767, -32768, 0}, 1'b0, zw},
      '{'{1, 0, 0, 0, 0, 0, 0}, 1'b0, zw},
      '{'{0, 0, 0, -1, 12, -5, 7}, 1'b0, zw},
      '{'{0, 0, 0, 0, 32767, 32767, -32768}, 1'b0, zw},
      '{'{-21846, 21845, -21846, 21845, -1, 0, -1}, 1'b0, zw}};
    seen_m = 1'b0;
    last_q = '{16384, 0, 0, 0};
    last_a = '{0, 0, 0};
    thrust_m = 12'd3277;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    foreach (dir[i]) send_word(dir[i].item, dir[i].typed, dir[i].word, $urandom_range(0, 3));
    @(negedge clk_i);
    in_valid_i = 1'b0;
    drain();

    // random phases, each under its own thrust setting
    thr_set = '{12'd4095, 12'd0, 12'($urandom), 12'd1};
    burst = 0;
    walk = '{16384, 0, 0, 0};
    for (int ph = 0; ph < 4; ph++) begin
      write_thrust(thr_set[ph]);
      repeat (2) @(posedge clk_i);
      for (int k = 0; k < 235; k++) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          // slowly rotating attitude, crosses hemispheres and wraps angles
          for (int j = 0; j < 4; j++)
            walk[j] = clip(walk[j] + $signed($urandom_range(0, 8000)) - 4000,
                           -32768, 32767);
          it.qw = 16'(walk[0]); it.qx = 16'(walk[1]);
          it.qy = 16'(walk[2]); it.qz = 16'(walk[3]);
        end else if (kind < 8) begin
          {it.qw, it.qx, it.qy, it.qz} = {$urandom, $urandom};
        end else begin
          it.qw = 16'($signed($urandom_range(0, 6)) - 3);
          it.qx = 16'($signed($urandom_range(0, 6)) - 3);
          it.qy = 16'($signed($urandom_range(0, 6)) - 3);
          it.qz = 16'($signed($urandom_range(0, 6)) - 3);
        end
        if ($urandom_range(0, 3) == 0) {it.rx, it.ry, it.rz} = {$urandom, $urandom};
        else begin
          it.rx = 16'($signed($urandom_range(0, 4000)) - 2000);
          it.ry = 16'($signed($urandom_range(0, 4000)) - 2000);
          it.rz = 16'($signed($urandom_range(0, 4000)) - 2000);
        end
        if (burst == 0) begin
          burst = $urandom_range(1, 10);
          gap = $urandom_range(1, 300);
        end else begin
          gap = 0;
        end
        burst--;
        if (ph == 1 && k == 100) long_hold_req = 1'b1;
        send_word(it, 1'b0, zw, burst == 0 ? gap : 0);
      end
      @(negedge clk_i);
      in_valid_i = 1'b0;
      drain();
    end

    repeat (300) @(posedge clk_i);
    $display("%0d words sent, %0d results checked over 5 thrust settings", n_sent, n_checked);
    $display("covered zero and extreme quaternions, hemisphere flips, angle wrap, rate limits");
    if (n_errors == 0 && expected_words.size() == 0) begin
      $display("attitude_state_feedback_core: match");
    end else begin
      $display("attitude_state_feedback_core: mismatch");
    end
    $finish;
  end

endmodule
